>>> sv/length_crc_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver modules.
`ifndef LENGTH_CRC_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_CRC_FRAME_RECEIVER_MACROS_SVH

// General form with an explicit clock and reset.
`define LCFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Form for modules whose clock and reset are named clock and reset.
`define LCFR_ASSERT_STD(label, prop, msg) \
   `LCFR_ASSERT(label, clock, reset, prop, msg)

`endif

>>> sv/lcfr_pkg.sv
// Package with types, codes and the CRC function of the frame receiver.
`default_nettype none

package lcfr_pkg;

   localparam logic [7:0]  START_BYTE    = 8'd2;
   localparam logic [7:0]  END_BYTE      = 8'd3;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_PAYLOAD,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_END
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_CRC_BAD,
      ST_BAD_END,
      ST_BAD_START,
      ST_TIMEOUT
   } status_type;

   typedef struct packed {
      logic       emit;
      logic       kind;
      logic [7:0] data_byte;
      logic [2:0] status;
      logic [7:0] frame_length;
      logic       last;
   } result_type;

   function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic result_type make_status(status_type st, logic [7:0] len);
      result_type r;
      r              = '0;
      r.emit         = 1'b1;
      r.kind         = KIND_STATUS;
      r.status       = st;
      r.frame_length = len;
      r.last         = 1'b1;
      return r;
   endfunction

   function automatic result_type make_payload(logic [7:0] b);
      result_type r;
      r           = '0;
      r.emit      = 1'b1;
      r.kind      = KIND_PAYLOAD;
      r.data_byte = b;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/lcfr_ifaces.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface lcfr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   modport source (output valid, op, rx_byte, input ready);
   modport sink (input valid, op, rx_byte, output ready);
endinterface

interface lcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [2:0] status;
   logic [7:0] frame_length;
   logic       last;
   modport source (output valid, kind, data_byte, status, frame_length, last, input ready);
   modport sink (input valid, kind, data_byte, status, frame_length, last, output ready);
endinterface

`default_nettype wire

>>> sv/length_crc_frame_receiver.sv
// A result appears on the response channel in the cycle after its request transfer.
// Throughput: one request transfer per cycle, held back only when the result register is
// full and the response channel is stalled.
// Reset (synchronous): returns to hunting for the start byte, clears the frame state and
// the result register, and sets the timeout to 100 ticks.
`default_nettype none

module length_crc_frame_receiver (
   input  wire logic   clock,
   input  wire logic   reset,
   lcfr_req_if.sink    req_chan,
   lcfr_rsp_if.source  rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [15:0]          timeout_ticks_ff, timeout_ticks_in;
   logic                 in_fire;
   logic                 in_ready;
   lcfr_pkg::result_type result;
   lcfr_pkg::result_type out_data;

   assign timeout_ticks_in = csr_wr_en ? csr_wr_data : timeout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= lcfr_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   assign req_chan.ready = in_ready;
   assign in_fire        = req_chan.valid && in_ready;

   lcfr_decoder u_decoder (
      .clock         (clock),
      .reset         (reset),
      .in_fire       (in_fire),
      .op            (req_chan.op),
      .rx_byte       (req_chan.rx_byte),
      .timeout_ticks (timeout_ticks_ff),
      .result        (result)
   );

   lcfr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .result    (result),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .in_ready  (in_ready)
   );

   assign rsp_chan.kind         = out_data.kind;
   assign rsp_chan.data_byte    = out_data.data_byte;
   assign rsp_chan.status       = out_data.status;
   assign rsp_chan.frame_length = out_data.frame_length;
   assign rsp_chan.last         = out_data.last;

endmodule

`default_nettype wire

>>> sv/lcfr_decoder.sv
// Frame phase logic, CRC accumulation and tick timeout for each accepted transfer.
`default_nettype none
`include "length_crc_frame_receiver_macros.svh"

module lcfr_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_fire,
   input  wire logic               op,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [15:0]        timeout_ticks,
   output lcfr_pkg::result_type    result
);

   lcfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  payload_length_ff, payload_length_in;
   logic [7:0]  bytes_seen_ff, bytes_seen_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] received_crc_ff, received_crc_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [15:0] tick_sat;
   logic [7:0]  bytes_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= lcfr_pkg::PH_HUNT;
         payload_length_ff <= '0;
         bytes_seen_ff     <= '0;
         running_crc_ff    <= '0;
         received_crc_ff   <= '0;
         tick_count_ff     <= '0;
      end else begin
         phase_ff          <= phase_in;
         payload_length_ff <= payload_length_in;
         bytes_seen_ff     <= bytes_seen_in;
         running_crc_ff    <= running_crc_in;
         received_crc_ff   <= received_crc_in;
         tick_count_ff     <= tick_count_in;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      payload_length_in = payload_length_ff;
      bytes_seen_in     = bytes_seen_ff;
      running_crc_in    = running_crc_ff;
      received_crc_in   = received_crc_ff;
      tick_count_in     = tick_count_ff;
      result            = '0;
      tick_sat          = (tick_count_ff == 16'hFFFF) ? tick_count_ff : tick_count_ff + 16'd1;
      bytes_next        = bytes_seen_ff + 8'd1;
      if (in_fire) begin
         if (op == lcfr_pkg::OP_TICK) begin
            if (phase_ff != lcfr_pkg::PH_HUNT) begin
               tick_count_in = tick_sat;
               if (tick_sat >= timeout_ticks) begin
                  result   = lcfr_pkg::make_status(lcfr_pkg::ST_TIMEOUT, payload_length_ff);
                  phase_in = lcfr_pkg::PH_HUNT;
               end
            end
         end else begin
            case (phase_ff)
               lcfr_pkg::PH_LEN: begin
                  payload_length_in = rx_byte;
                  bytes_seen_in     = '0;
                  phase_in = (rx_byte == 8'd0) ? lcfr_pkg::PH_CRC_HI : lcfr_pkg::PH_PAYLOAD;
               end
               lcfr_pkg::PH_PAYLOAD: begin
                  running_crc_in = lcfr_pkg::crc16_update(running_crc_ff, rx_byte);
                  bytes_seen_in  = bytes_next;
                  if (bytes_next == payload_length_ff) begin
                     phase_in = lcfr_pkg::PH_CRC_HI;
                  end
                  result = lcfr_pkg::make_payload(rx_byte);
               end
               lcfr_pkg::PH_CRC_HI: begin
                  received_crc_in = {rx_byte, 8'h00};
                  phase_in        = lcfr_pkg::PH_CRC_LO;
               end
               lcfr_pkg::PH_CRC_LO: begin
                  received_crc_in = {received_crc_ff[15:8], rx_byte};
                  phase_in        = lcfr_pkg::PH_END;
               end
               lcfr_pkg::PH_END: begin
                  phase_in = lcfr_pkg::PH_HUNT;
                  if (rx_byte != lcfr_pkg::END_BYTE) begin
                     result = lcfr_pkg::make_status(lcfr_pkg::ST_BAD_END, payload_length_ff);
                  end else if (received_crc_ff == running_crc_ff) begin
                     result = lcfr_pkg::make_status(lcfr_pkg::ST_OK, payload_length_ff);
                  end else begin
                     result = lcfr_pkg::make_status(lcfr_pkg::ST_CRC_BAD, payload_length_ff);
                  end
               end
               default: begin
                  if (rx_byte == lcfr_pkg::START_BYTE) begin
                     phase_in          = lcfr_pkg::PH_LEN;
                     payload_length_in = '0;
                     bytes_seen_in     = '0;
                     running_crc_in    = '0;
                     received_crc_in   = '0;
                     tick_count_in     = '0;
                  end else begin
                     phase_in          = lcfr_pkg::PH_HUNT;
                     payload_length_in = '0;
                     result = lcfr_pkg::make_status(lcfr_pkg::ST_BAD_START, 8'd0);
                  end
               end
            endcase
         end
      end
   end

   // A status always closes the frame.
   `LCFR_ASSERT_STD(a_status_returns_to_hunt,
      in_fire && result.emit && result.kind == lcfr_pkg::KIND_STATUS |=>
      phase_ff == lcfr_pkg::PH_HUNT,
      "status transfer did not return the decoder to hunting")

   `LCFR_ASSERT_STD(a_payload_count_bounded,
      phase_ff == lcfr_pkg::PH_PAYLOAD |-> bytes_seen_ff < payload_length_ff,
      "payload byte count reached the announced length inside the payload phase")

   `LCFR_ASSERT_STD(a_hunt_tick_silent,
      in_fire && op == lcfr_pkg::OP_TICK && phase_ff == lcfr_pkg::PH_HUNT |->
      !result.emit ##1 $stable(tick_count_ff),
      "tick while hunting produced a result")

endmodule

`default_nettype wire

>>> sv/lcfr_out_reg.sv
// Result register that holds one transfer for the response channel.
`default_nettype none
`include "length_crc_frame_receiver_macros.svh"

module lcfr_out_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_fire,
   input  wire lcfr_pkg::result_type result,
   input  wire logic             out_ready,
   output logic                  out_valid,
   output lcfr_pkg::result_type  out_data,
   output logic                  in_ready
);

   logic                 valid_ff, valid_in;
   lcfr_pkg::result_type data_ff, data_in;
   logic                 load;

   assign load     = in_fire && result.emit;
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `LCFR_ASSERT_STD(a_load_shows_result,
      load |=> valid_ff,
      "accepted result did not appear on the response channel")

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the length and CRC framed byte receiver.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 200_000;

   typedef struct {
      logic       op;
      logic [7:0] rx_byte;
   } serial_item_type;

   typedef struct packed {
      logic                 kind;
      logic [7:0]           data_byte;
      lcfr_pkg::status_type status;
      logic [7:0]           frame_length;
      logic                 last;
   } frame_result_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   lcfr_req_if req_chan();
   lcfr_rsp_if rsp_chan();

   length_crc_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   serial_item_type  pending_items[$];
   frame_result_type expected_results[$];

   int accepted_count = 0;
   int offer_idx = -1;
   int burst_left = 0;
   int gap_left = 0;
   int failures = 0;
   int payload_count = 0;
   int status_count = 0;
   int status_seen[5] = '{default: 0};
   longint cycle_count = 0;

   int hold_left = 0;
   bit hold_done = 1'b0;
   int ready_mode = 0;
   int mode_left = 0;
   int pattern_cnt = 0;

   lcfr_pkg::phase_type rx_phase;
   logic [7:0]  rx_len;
   logic [7:0]  rx_seen;
   logic [15:0] run_crc;
   logic [15:0] rx_crc;
   logic [15:0] tick_total;
   logic [15:0] tick_limit;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0} ^ (fb ? lcfr_pkg::CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic frame_result_type close_frame(lcfr_pkg::status_type st);
      frame_result_type r;
      r = '0;
      r.kind = lcfr_pkg::KIND_STATUS;
      r.status = st;
      r.frame_length = rx_len;
      r.last = 1'b1;
      rx_phase = lcfr_pkg::PH_HUNT;
      return r;
   endfunction

   task automatic decode_step(input logic op, input logic [7:0] b, output bit produced,
                              output frame_result_type res);
      produced = 1'b0;
      res = '0;
      if (op == lcfr_pkg::OP_TICK) begin
         if (rx_phase != lcfr_pkg::PH_HUNT) begin
            if (tick_total != 16'hFFFF) begin
               tick_total++;
            end
            if (tick_total >= tick_limit) begin
               res = close_frame(lcfr_pkg::ST_TIMEOUT);
               produced = 1'b1;
            end
         end
      end else begin
         case (rx_phase)
            lcfr_pkg::PH_LEN: begin
               rx_len = b;
               rx_seen = 8'd0;
               if (b == 8'd0) begin
                  rx_phase = lcfr_pkg::PH_CRC_HI;
               end else begin
                  rx_phase = lcfr_pkg::PH_PAYLOAD;
               end
            end
            lcfr_pkg::PH_PAYLOAD: begin
               run_crc = crc_next(run_crc, b);
               rx_seen++;
               if (rx_seen == rx_len) begin
                  rx_phase = lcfr_pkg::PH_CRC_HI;
               end
               res.kind = lcfr_pkg::KIND_PAYLOAD;
               res.data_byte = b;
               produced = 1'b1;
            end
            lcfr_pkg::PH_CRC_HI: begin
               rx_crc = {b, 8'h00};
               rx_phase = lcfr_pkg::PH_CRC_LO;
            end
            lcfr_pkg::PH_CRC_LO: begin
               rx_crc[7:0] = b;
               rx_phase = lcfr_pkg::PH_END;
            end
            lcfr_pkg::PH_END: begin
               produced = 1'b1;
               if (b != lcfr_pkg::END_BYTE) begin
                  res = close_frame(lcfr_pkg::ST_BAD_END);
               end else if (rx_crc == run_crc) begin
                  res = close_frame(lcfr_pkg::ST_OK);
               end else begin
                  res = close_frame(lcfr_pkg::ST_CRC_BAD);
               end
            end
            default: begin
               if (b == lcfr_pkg::START_BYTE) begin
                  rx_phase = lcfr_pkg::PH_LEN;
                  rx_len = 8'd0;
                  rx_seen = 8'd0;
                  run_crc = 16'd0;
                  rx_crc = 16'd0;
                  tick_total = 16'd0;
               end else begin
                  rx_len = 8'd0;
                  res = close_frame(lcfr_pkg::ST_BAD_START);
                  produced = 1'b1;
               end
            end
         endcase
      end
   endtask

   always @(negedge clock) begin : drive_req
      serial_item_type item;
      bit              show;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!(req_chan.valid && offer_idx == accepted_count)) begin
         show = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (accepted_count < pending_items.size()) begin
            show = 1'b1;
            offer_idx = accepted_count;
            item = pending_items[offer_idx];
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (show) begin
            req_chan.valid <= 1'b1;
            req_chan.op <= item.op;
            req_chan.rx_byte <= item.rx_byte;
         end else begin
            req_chan.valid <= 1'b0;
            req_chan.op <= 1'($urandom_range(0, 1));
            req_chan.rx_byte <= 8'($urandom_range(0, 255));
         end
      end
   end

   always @(negedge clock) begin : drive_rsp_ready
      logic rdy;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (hold_left == 0 && !hold_done && accepted_count >= 300) begin
            hold_done = 1'b1;
            hold_left = 80;
         end else if (hold_left == 0 && $urandom_range(0, 1999) == 0) begin
            hold_left = $urandom_range(30, 90);
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            pattern_cnt++;
            case (ready_mode)
               0: rdy = 1'b1;
               1: rdy = 1'($urandom_range(0, 1));
               2: rdy = ($urandom_range(0, 9) != 0);
               default: rdy = (pattern_cnt % 5 < 2);
            endcase
         end
         rsp_chan.ready <= rdy;
      end
   end

   always @(posedge clock) begin : watch_channels
      frame_result_type predicted;
      frame_result_type want;
      bit               produced;
      if (reset) begin
         rx_phase = lcfr_pkg::PH_HUNT;
         rx_len = 8'd0;
         rx_seen = 8'd0;
         run_crc = 16'd0;
         rx_crc = 16'd0;
         tick_total = 16'd0;
         tick_limit = lcfr_pkg::TIMEOUT_RESET;
         expected_results.delete();
      end else begin
         if (csr_wr_en) begin
            tick_limit = csr_wr_data;
         end
         if (req_chan.valid && req_chan.ready) begin
            decode_step(req_chan.op, req_chan.rx_byte, produced, predicted);
            if (produced) begin
               expected_results.push_back(predicted);
            end
            accepted_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("Response transfer arrived with no result expected.");
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_chan.kind);
                  failures++;
               end
               if (rsp_chan.data_byte !== want.data_byte) begin
                  $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte,
                         rsp_chan.data_byte);
                  failures++;
               end
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  failures++;
               end
               if (rsp_chan.frame_length !== want.frame_length) begin
                  $error("frame_length: expected %0d, got %0d", want.frame_length,
                         rsp_chan.frame_length);
                  failures++;
               end
               if (rsp_chan.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_chan.last);
                  failures++;
               end
               if (want.kind == lcfr_pkg::KIND_STATUS) begin
                  status_count++;
                  status_seen[int'(want.status)]++;
               end else begin
                  payload_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("length_crc_frame_receiver verification failed");
         $finish;
      end
   end

   task automatic push_byte(logic [7:0] b);
      serial_item_type item;
      item.op = lcfr_pkg::OP_BYTE;
      item.rx_byte = b;
      pending_items.push_back(item);
   endtask

   task automatic push_tick();
      serial_item_type item;
      item.op = lcfr_pkg::OP_TICK;
      item.rx_byte = 8'($urandom_range(0, 255));
      pending_items.push_back(item);
   endtask

   task automatic maybe_ticks(int tick_pct);
      if ($urandom_range(0, 99) < tick_pct) begin
         repeat ($urandom_range(1, 3)) push_tick();
      end
   endtask

   // A fill below zero gives random payload bytes.
   task automatic push_frame(int len, int fill, bit bad_crc, bit bad_end, int tick_pct);
      logic [15:0] crc;
      logic [7:0]  b;
      logic [7:0]  tail;
      crc = 16'd0;
      push_byte(lcfr_pkg::START_BYTE);
      maybe_ticks(tick_pct);
      push_byte(8'(len));
      for (int i = 0; i < len; i++) begin
         maybe_ticks(tick_pct);
         b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         crc = crc_next(crc, b);
         push_byte(b);
      end
      if (bad_crc) begin
         crc ^= 16'($urandom_range(1, 65535));
      end
      maybe_ticks(tick_pct);
      push_byte(crc[15:8]);
      maybe_ticks(tick_pct);
      push_byte(crc[7:0]);
      maybe_ticks(tick_pct);
      tail = lcfr_pkg::END_BYTE;
      if (bad_end) begin
         tail = 8'($urandom_range(0, 255));
         if (tail == lcfr_pkg::END_BYTE) begin
            tail = ~tail;
         end
      end
      push_byte(tail);
   endtask

   task automatic random_traffic(int count, int tick_pct);
      int goal;
      int pick;
      int len;
      goal = pending_items.size() + count;
      while (pending_items.size() < goal) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
         if (pick < 70) begin
            push_frame(len, -1, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                       tick_pct);
         end else if (pick < 82) begin
            push_byte(8'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            push_byte(lcfr_pkg::START_BYTE);
            push_byte(8'(len));
            repeat ($urandom_range(0, len)) push_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) push_tick();
         end
      end
   endtask

   task automatic wait_idle();
      while (accepted_count < pending_items.size() || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic write_timeout(logic [15:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 16'd0;
      req_chan.valid = 1'b0;
      req_chan.op = 1'b0;
      req_chan.rx_byte = 8'd0;
      rsp_chan.ready = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      push_tick();
      push_byte(lcfr_pkg::END_BYTE);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_frame(0, 0, 1'b0, 1'b0, 0);
      push_frame(1, 255, 1'b0, 1'b0, 0);
      push_frame(2, 0, 1'b1, 1'b0, 0);
      push_frame(1, 255, 1'b0, 1'b1, 0);
      push_frame(2, -1, 1'b0, 1'b0, 50);
      push_frame(255, -1, 1'b0, 1'b0, 0);
      random_traffic(250, 5);

      write_timeout(16'd1);
      push_byte(lcfr_pkg::START_BYTE);
      push_tick();
      push_byte(lcfr_pkg::START_BYTE);
      push_byte(8'd5);
      push_tick();
      random_traffic(250, 10);

      write_timeout(16'd3);
      random_traffic(250, 20);

      write_timeout(16'hFFFF);
      random_traffic(250, 20);

      write_timeout(16'($urandom_range(5, 40)));
      random_traffic(250, 30);

      wait_idle();
      $display("Checked %0d request transfers: %0d payload bytes and %0d frame statuses.",
               accepted_count, payload_count, status_count);
      $display("Statuses: ok %0d, crc mismatch %0d, bad end %0d, bad start %0d, timeout %0d.",
               status_seen[int'(lcfr_pkg::ST_OK)], status_seen[int'(lcfr_pkg::ST_CRC_BAD)],
               status_seen[int'(lcfr_pkg::ST_BAD_END)],
               status_seen[int'(lcfr_pkg::ST_BAD_START)],
               status_seen[int'(lcfr_pkg::ST_TIMEOUT)]);
      if (failures == 0) begin
         $display("length_crc_frame_receiver verification clean");
      end else begin
         $display("length_crc_frame_receiver verification failed");
      end
      $finish;
   end

endmodule
